FILE: hw/rtl/bcfa_pkg.sv
// Package for the bitmap first-fit frame allocator: sizes, request/status codes,
// sequencer states and the bitmap write struct. No dependencies.
package bcfa_pkg;

    localparam int FRAMES      = 256;
    localparam int PAGE_SHIFT  = 12;
    localparam int WORD_BITS   = 32;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int MAP_WORDS   = (FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int FRAME_W     = $clog2(FRAMES);
    localparam int CNT_W       = $clog2(FRAMES + 1);
    localparam int PAGE_NUM_W  = 32 - PAGE_SHIFT;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_MARK  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DECIDE,
        S_SCAN,
        S_FILL,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic               en;
        logic [FRAME_W-1:0] frame;
        logic               used;
    } map_wr_t;

endpackage

FILE: hw/rtl/bitmap_contiguous_frame_allocator.sv
// Bitmap first-fit allocator over FRAMES pages of 4 KiB above region_base.
// Depends on bcfa_pkg and bcfa_map.
//
//   channel   signals                                   direction
//   req       req_valid/req_stall, mode, frame_count,   in  (stall driven here)
//             phys_address
//   rsp       rsp_valid/rsp_stall, result_address,      out (stall from sink)
//             status
//   cfg       cfg_wr_en, cfg_wr_data (region_base)      in, no wait
//
// One item at a time; req_stall is low only while the sequencer is idle.
// Allocate: CHECK and DECIDE set up, SCAN walks the bitmap positions (up to
// the usable frame count), FILL marks the run found, FINISH loads the result.
// Free/mark: CHECK, DECIDE, FILL per frame, FINISH; a zero count or a range
// fault goes from DECIDE straight to FINISH. One bitmap bit is read and one
// written at a time. Reset clears the bitmap at once; the result register
// holds while rsp_stall is high and the next item can be taken meanwhile.
module bitmap_contiguous_frame_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  mode,
    input  logic [8:0]  frame_count,
    input  logic [31:0] phys_address,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [31:0] result_address,
    output logic [1:0]  status
);

    localparam int FW = bcfa_pkg::FRAME_W;
    localparam int CW = bcfa_pkg::CNT_W;
    localparam int PW = bcfa_pkg::PAGE_NUM_W;

    bcfa_pkg::state_t state_reg, state_next;

    logic [31:0]   base_reg;
    logic [1:0]    mode_reg, mode_next;
    logic [8:0]    n_reg, n_next;
    logic [31:0]   addr_reg, addr_next;
    logic [CW-1:0] limit_reg, limit_next;
    logic [PW-1:0] off_reg, off_next;
    logic          below_reg, below_next;
    logic [FW-1:0] frame_reg, frame_next;
    logic [CW-1:0] run_reg, run_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [31:0]   res_addr_reg, res_addr_next;
    logic [1:0]    res_status_reg, res_status_next;

    logic          rsp_valid_reg, rsp_valid_next;
    logic [31:0]   rsp_addr_reg, rsp_addr_next;
    logic [1:0]    rsp_status_reg, rsp_status_next;

    logic          req_take;
    logic          out_free;
    logic          used;
    bcfa_pkg::map_wr_t map_wr;

    logic [31:0]   base_addr;
    logic [PW:0]   room;
    logic [32:0]   diff;
    logic [PW:0]   run_end;
    logic          range_bad;
    logic [CW-1:0] run_inc;
    logic          hit;
    logic          last_pos;
    logic [FW-1:0] first;

    assign req_stall = (state_reg != bcfa_pkg::S_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid      = rsp_valid_reg;
    assign result_address = rsp_addr_reg;
    assign status         = rsp_status_reg;

    assign base_addr = {base_reg[31:bcfa_pkg::PAGE_SHIFT], {bcfa_pkg::PAGE_SHIFT{1'b0}}};
    // pages left below 2^32; S_CHECK clips this to the bitmap size into limit_reg
    assign room      = {1'b1, {PW{1'b0}}} - {1'b0, base_reg[31:bcfa_pkg::PAGE_SHIFT]};
    assign diff      = {1'b0, addr_reg} - {1'b0, base_addr};
    assign run_end   = (PW+1)'(off_reg) + (PW+1)'(n_reg);
    assign range_bad = below_reg || (run_end > (PW+1)'(limit_reg));

    assign run_inc  = used ? '0 : run_reg + CW'(1);
    assign hit      = (32'(run_inc) == 32'(n_reg));
    assign last_pos = (32'(frame_reg) + 32'd1 == 32'(limit_reg));
    assign first    = frame_reg + FW'(1) - FW'(n_reg);

    bcfa_map u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_frame (frame_reg),
        .rd_used  (used),
        .wr       (map_wr)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bcfa_pkg::S_IDLE:
            begin
                if (req_take)
                begin
                    state_next = bcfa_pkg::S_CHECK;
                end
            end
            bcfa_pkg::S_CHECK:
            begin
                state_next = bcfa_pkg::S_DECIDE;
            end
            bcfa_pkg::S_DECIDE:
            begin
                state_next = bcfa_pkg::S_FINISH;
                if (n_reg != '0)
                begin
                    if (mode_reg == bcfa_pkg::MODE_ALLOC)
                    begin
                        state_next = bcfa_pkg::S_SCAN;
                    end
                    else if ((mode_reg == bcfa_pkg::MODE_FREE ||
                              mode_reg == bcfa_pkg::MODE_MARK) && !range_bad)
                    begin
                        state_next = bcfa_pkg::S_FILL;
                    end
                end
            end
            bcfa_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    state_next = bcfa_pkg::S_FILL;
                end
                else if (last_pos)
                begin
                    state_next = bcfa_pkg::S_FINISH;
                end
            end
            bcfa_pkg::S_FILL:
            begin
                if (rem_reg == CW'(1))
                begin
                    state_next = bcfa_pkg::S_FINISH;
                end
            end
            bcfa_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = bcfa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bcfa_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        mode_next       = mode_reg;
        n_next          = n_reg;
        addr_next       = addr_reg;
        limit_next      = limit_reg;
        off_next        = off_reg;
        below_next      = below_reg;
        frame_next      = frame_reg;
        run_next        = run_reg;
        rem_next        = rem_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        rsp_addr_next   = rsp_addr_reg;
        rsp_status_next = rsp_status_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        map_wr.en       = 1'b0;
        map_wr.frame    = frame_reg;
        map_wr.used     = (mode_reg != bcfa_pkg::MODE_FREE);

        case (state_reg)
            bcfa_pkg::S_IDLE:
            begin
                if (req_take)
                begin
                    mode_next = mode;
                    n_next    = frame_count;
                    addr_next = phys_address;
                end
            end
            bcfa_pkg::S_CHECK:
            begin
                limit_next = (room < (PW+1)'(bcfa_pkg::FRAMES)) ?
                             CW'(room) : CW'(bcfa_pkg::FRAMES);
                below_next = diff[32];
                off_next   = diff[31:bcfa_pkg::PAGE_SHIFT];
            end
            bcfa_pkg::S_DECIDE:
            begin
                res_addr_next   = '0;
                res_status_next = bcfa_pkg::ST_OK;
                frame_next      = '0;
                run_next        = '0;
                rem_next        = CW'(n_reg);
                if (mode_reg == bcfa_pkg::MODE_ALLOC)
                begin
                    if (n_reg == '0)
                    begin
                        res_addr_next = base_addr;
                    end
                end
                else if (mode_reg == bcfa_pkg::MODE_FREE || mode_reg == bcfa_pkg::MODE_MARK)
                begin
                    if (n_reg != '0)
                    begin
                        if (range_bad)
                        begin
                            res_status_next = bcfa_pkg::ST_RANGE;
                        end
                        frame_next = FW'(off_reg);
                    end
                end
            end
            bcfa_pkg::S_SCAN:
            begin
                run_next   = run_inc;
                frame_next = frame_reg + FW'(1);
                if (hit)
                begin
                    frame_next    = first;
                    res_addr_next = base_addr + (32'(first) << bcfa_pkg::PAGE_SHIFT);
                end
                else if (last_pos)
                begin
                    res_status_next = bcfa_pkg::ST_NOSPACE;
                end
            end
            bcfa_pkg::S_FILL:
            begin
                map_wr.en  = 1'b1;
                frame_next = frame_reg + FW'(1);
                rem_next   = rem_reg - CW'(1);
            end
            bcfa_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_addr_next   = res_addr_reg;
                    rsp_status_next = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bcfa_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
            base_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        n_reg          <= n_next;
        addr_reg       <= addr_next;
        limit_reg      <= limit_next;
        off_reg        <= off_next;
        below_reg      <= below_next;
        frame_reg      <= frame_next;
        run_reg        <= run_next;
        rem_reg        <= rem_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        rsp_addr_reg   <= rsp_addr_next;
        rsp_status_reg <= rsp_status_next;
    end

endmodule

FILE: hw/rtl/bcfa_map.sv
// Occupancy bitmap: one bit per frame in 32-bit words, one bit read and one
// bit written per cycle. Depends on bcfa_pkg.
module bcfa_map (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [bcfa_pkg::FRAME_W-1:0]   rd_frame,
    output logic                           rd_used,
    input  bcfa_pkg::map_wr_t              wr
);

    logic [bcfa_pkg::WORD_BITS-1:0] words_reg [bcfa_pkg::MAP_WORDS];

    logic [bcfa_pkg::WIDX_W-1:0] rd_word;
    logic [bcfa_pkg::BIT_W-1:0]  rd_bit;
    logic [bcfa_pkg::WIDX_W-1:0] wr_word;
    logic [bcfa_pkg::BIT_W-1:0]  wr_bit;

    assign rd_word = bcfa_pkg::WIDX_W'(rd_frame >> bcfa_pkg::BIT_W);
    assign rd_bit  = rd_frame[bcfa_pkg::BIT_W-1:0];
    assign wr_word = bcfa_pkg::WIDX_W'(wr.frame >> bcfa_pkg::BIT_W);
    assign wr_bit  = wr.frame[bcfa_pkg::BIT_W-1:0];

    assign rd_used = words_reg[rd_word][rd_bit];

    // reset leaves every frame free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < bcfa_pkg::MAP_WORDS; w++)
            begin
                words_reg[w] <= '0;
            end
        end
        else if (wr.en)
        begin
            words_reg[wr_word][wr_bit] <= wr.used;
        end
    end

endmodule

FILE: hw/rtl/bcfa_chk.sv
// Port-level checks for the frame allocator, bound to the top level.
// Depends on bcfa_pkg and bitmap_contiguous_frame_allocator.
module bcfa_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [31:0] result_address,
    input logic [1:0]  status
);

    // a taken item makes the block busy: req_stall rises after the take
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while previous one in flight");

    // taking an item does not itself raise rsp_valid; a result already shown may stay
    a_no_instant_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> !rsp_valid || $past(rsp_valid) || $stable(rsp_valid))
        else $error("result appeared too early");

    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == bcfa_pkg::ST_NOSPACE || status == bcfa_pkg::ST_RANGE)
        |-> result_address == '0)
        else $error("failed item returned an address");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == bcfa_pkg::ST_OK || status == bcfa_pkg::ST_NOSPACE ||
                       status == bcfa_pkg::ST_RANGE))
        else $error("undefined status code");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(result_address) && $stable(status))
        else $error("stalled result changed");

endmodule

bind bitmap_contiguous_frame_allocator bcfa_chk u_bcfa_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .result_address (result_address),
    .status         (status)
);
